// File: rtl/vertex_transform_4x4_top_defines.svh
// assertion macros shared by the checker files
`ifndef VERTEX_TRANSFORM_4X4_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_TOP_DEFINES_SVH

// implication in the same cycle, off while reset is low
`define VT4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, off while reset is low
`define VT4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after a reset cycle
`define VT4_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/vt4_pkg.sv
package vt4_pkg;

    localparam int NUM_DIM        = 4;
    localparam int FIELD_W        = 32;
    localparam int REG_W          = 64;
    localparam int SLOT_BITS      = 16;
    localparam int Q_INT_BITS     = 4;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = NUM_DIM * FIELD_W;
    localparam int OUT_TDATA_W = ((NUM_DIM * FIELD_W + 1 + 7) / 8) * 8;

    // identity matrix, one 0x1000 per row on the diagonal
    localparam logic [REG_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [REG_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [REG_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [REG_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    typedef enum logic [1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } t_cfg_idx;

endpackage

// File: rtl/vt4_mul.sv
module vt4_mul import vt4_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_next_ready,
    output logic                                   o_ready,
    input  logic signed [DATA_WIDTH-1:0]           i_vertex [NUM_DIM],
    input  logic signed [COEF_WIDTH-1:0]           i_coef   [NUM_DIM][NUM_DIM],
    output logic                                   o_valid,
    output logic signed [DATA_WIDTH+COEF_WIDTH-1:0] o_prod  [NUM_DIM][NUM_DIM]
);

    localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;

    logic                     r_valid;
    logic signed [PROD_W-1:0] r_prod [NUM_DIM][NUM_DIM];
    logic                     n_load;

    // stage takes a new item when empty or when its content moves on
    assign n_load  = !r_valid || i_next_ready;
    assign o_ready = n_load;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= i_valid;
        end
    end

    // sixteen products, row r of the matrix scales component r
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            for (int r = 0; r < NUM_DIM; r++) begin
                for (int c = 0; c < NUM_DIM; c++) begin
                    r_prod[r][c] <= i_vertex[r] * i_coef[r][c];
                end
            end
        end
    end

endmodule

// File: rtl/vt4_acc.sv
module vt4_acc import vt4_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [DATA_WIDTH+COEF_WIDTH-1:0] i_prod [NUM_DIM][NUM_DIM],
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [DATA_WIDTH-1:0]            o_res  [NUM_DIM],
    output logic                                    o_ovf
);

    localparam int PROD_W    = DATA_WIDTH + COEF_WIDTH;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int COEF_FRAC = COEF_WIDTH - Q_INT_BITS;
    localparam int Q_W       = SUM_W - COEF_FRAC;

    logic                     r_pair_valid;
    logic                     r_sum_valid;
    logic                     r_out_valid;
    logic signed [PAIR_W-1:0] r_pair_lo [NUM_DIM];
    logic signed [PAIR_W-1:0] r_pair_hi [NUM_DIM];
    logic signed [SUM_W-1:0]  r_sum     [NUM_DIM];
    logic signed [DATA_WIDTH-1:0] r_res [NUM_DIM];
    logic                     r_ovf;

    logic                     n_out_load;
    logic                     n_sum_load;
    logic                     n_pair_load;
    logic signed [Q_W-1:0]    n_q   [NUM_DIM];
    logic signed [DATA_WIDTH-1:0] n_res [NUM_DIM];
    logic [NUM_DIM-1:0]       n_clip;

    assign n_out_load  = !r_out_valid || i_ready;
    assign n_sum_load  = !r_sum_valid || n_out_load;
    assign n_pair_load = !r_pair_valid || n_sum_load;
    assign o_ready     = n_pair_load;
    assign o_valid     = r_out_valid;
    assign o_res       = r_res;
    assign o_ovf       = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (n_pair_load) begin
                r_pair_valid <= i_valid;
            end
            if (n_sum_load) begin
                r_sum_valid <= r_pair_valid;
            end
            if (n_out_load) begin
                r_out_valid <= r_sum_valid;
            end
        end
    end

    // floor shift, then clamp to the signed data range
    always_comb begin
        for (int c = 0; c < NUM_DIM; c++) begin
            n_q[c] = Q_W'(r_sum[c] >>> COEF_FRAC);
            if (!n_q[c][Q_W-1] && (n_q[c][Q_W-2:DATA_WIDTH-1] != '0)) begin
                n_res[c]  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                n_clip[c] = 1'b1;
            end else if (n_q[c][Q_W-1] && !(&n_q[c][Q_W-2:DATA_WIDTH-1])) begin
                n_res[c]  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
                n_clip[c] = 1'b1;
            end else begin
                n_res[c]  = n_q[c][DATA_WIDTH-1:0];
                n_clip[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_pair_load) begin
            for (int c = 0; c < NUM_DIM; c++) begin
                r_pair_lo[c] <= PAIR_W'(i_prod[0][c]) + PAIR_W'(i_prod[1][c]);
                r_pair_hi[c] <= PAIR_W'(i_prod[2][c]) + PAIR_W'(i_prod[3][c]);
            end
        end
        if (n_sum_load) begin
            for (int c = 0; c < NUM_DIM; c++) begin
                r_sum[c] <= SUM_W'(r_pair_lo[c]) + SUM_W'(r_pair_hi[c]);
            end
        end
        if (n_out_load) begin
            r_res <= n_res;
            r_ovf <= |n_clip;
        end
    end

endmodule

// File: rtl/vertex_transform_4x4_top.sv
// vertex transform: one homogeneous vertex (x, y, z, w) times a 4x4 matrix,
// row-vector form, out[c] = sum over r of in[r] * m[r][c]
// input stream: tdata carries x, y, z, w, 32 bits each, x lowest, signed q16.16
// output stream: tdata carries x, y, z, w of the result and the overflow flag
// matrix: four 64-bit row registers on the write port, four signed q4.12
// coefficients each, column c in bits 16c+15..16c; write only while idle
// results are summed at full width, shifted right by 12 (toward minus infinity)
// and clamped to the data range; overflow is set if any component clamped
// each result passes the multiply, pair add, final add and output registers in turn
// throughput: one vertex per cycle while output tready is high, set by four
// register stages (multiply, pair add, final add, shift and clamp) all moving
// stalls: when the receiver holds tready low, stages fill up behind the output
// register and the input tready falls only once every stage holds an item
// reset: synchronous, clears all stage valid bits and loads the identity matrix
module vertex_transform_4x4_top import vt4_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // x_in, y_in, z_in, w_in from the lowest bit up, 32 bits each
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // x_out, y_out, z_out, w_out (32 bits each), overflow, then zero fill
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // matrix row write port
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_addr,
    input  logic [REG_W-1:0]       i_cfg_wdata
);

    localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;

    logic [REG_W-1:0]             r_row [NUM_DIM];

    logic signed [DATA_WIDTH-1:0] n_vertex [NUM_DIM];
    logic signed [COEF_WIDTH-1:0] n_coef   [NUM_DIM][NUM_DIM];
    logic signed [PROD_W-1:0]     n_prod   [NUM_DIM][NUM_DIM];
    logic signed [DATA_WIDTH-1:0] n_res    [NUM_DIM];
    logic                         n_ovf;
    logic                         n_mul_valid;
    logic                         n_acc_ready;
    logic [NUM_DIM*FIELD_W-1:0]   n_out_fields;

    // matrix rows, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW0_RESET;
            r_row[1] <= ROW1_RESET;
            r_row[2] <= ROW2_RESET;
            r_row[3] <= ROW3_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ROW0: r_row[0] <= i_cfg_wdata;
                REG_ROW1: r_row[1] <= i_cfg_wdata;
                REG_ROW2: r_row[2] <= i_cfg_wdata;
                REG_ROW3: r_row[3] <= i_cfg_wdata;
                default:  ;
            endcase
        end
    end

    // low bits of each slot and field, taken as signed
    always_comb begin
        for (int r = 0; r < NUM_DIM; r++) begin
            n_vertex[r] = i_s_axis_tdata[r*FIELD_W +: DATA_WIDTH];
            for (int c = 0; c < NUM_DIM; c++) begin
                n_coef[r][c] = r_row[r][c*SLOT_BITS +: COEF_WIDTH];
            end
        end
    end

    vt4_mul #(
        .COEF_WIDTH (COEF_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_next_ready (n_acc_ready),
        .o_ready      (o_s_axis_tready),
        .i_vertex     (n_vertex),
        .i_coef       (n_coef),
        .o_valid      (n_mul_valid),
        .o_prod       (n_prod)
    );

    vt4_acc #(
        .COEF_WIDTH (COEF_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_mul_valid),
        .o_ready (n_acc_ready),
        .i_prod  (n_prod),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (n_res),
        .o_ovf   (n_ovf)
    );

    // results sign extended to the 32-bit fields
    always_comb begin
        for (int c = 0; c < NUM_DIM; c++) begin
            n_out_fields[c*FIELD_W +: FIELD_W] = FIELD_W'(n_res[c]);
        end
    end

    assign o_m_axis_tdata = OUT_TDATA_W'({n_ovf, n_out_fields});

endmodule

// File: rtl/vt4_checker.sv
`include "vertex_transform_4x4_top_defines.svh"

module vt4_checker import vt4_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // no result is left over from before reset
    `VT4_ASSERT_RESET(a_reset_empty, !o_m_axis_tvalid, "output valid right after reset")

    // a held result keeps its payload
    `VT4_ASSERT_NEXT(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // with an empty output register the pipeline always has room
    `VT4_ASSERT_NOW(a_room_when_empty, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output")

    // a transfer reaches the output while reset stays high and the receiver keeps taking
    `VT4_ASSERT_NOW(a_latency, $past(i_s_axis_tvalid && o_s_axis_tready, 4) && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) && $past(i_rst_n, 4) && $past(i_m_axis_tready, 1) && $past(i_m_axis_tready, 2) && $past(i_m_axis_tready, 3), o_m_axis_tvalid, "result missing after four cycles")

endmodule

bind vertex_transform_4x4_top vt4_checker u_vt4_checker (.*);
